// ===== hw/rtl/u2u8_pkg.sv =====
package u2u8_pkg;

  // code unit ranges
  localparam logic [15:0] HIGH_FIRST = 16'hd800;
  localparam logic [15:0] HIGH_LAST  = 16'hdbff;
  localparam logic [15:0] LOW_FIRST  = 16'hdc00;
  localparam logic [15:0] LOW_LAST   = 16'hdfff;
  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // utf-8 lead and continuation marks
  localparam logic [7:0] LEAD4 = 8'b1111_0000;
  localparam logic [7:0] LEAD3 = 8'b1110_0000;
  localparam logic [7:0] LEAD2 = 8'b1100_0000;
  localparam logic [7:0] CONT  = 8'b1000_0000;

  // most bytes one unit can cause (held high flushed plus a new unit)
  localparam int MAX_BYTES = 6;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  // default queue depth between front and back
  localparam int FIFO_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_done;
  } out_word_t;

  // one queued job: the bytes of one input word, first byte at index 0
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      eos;
  } job_t;

  // queue status: full drives in_stall, head_valid is seen by the back
  typedef struct packed {
    logic full;
    logic head_valid;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/utf16_to_utf8_transcoder.sv =====
// channel | direction | word type  | handshake
// in      | input     | in_word_t  | in_valid / in_stall
// out     | output    | out_word_t | out_valid / out_stall
//
// output runs at one byte per cycle while out_stall is low; a word causes 1 to 4
// bytes (3 to 6 when a held high surrogate is flushed); a held high surrogate causes
// none, so the single-byte output register sets the rate. in_stall is high only
// while the queue is full. a word is encoded and queued at the edge it is taken;
// from an empty pipe its first byte then passes the job and output registers.
// out_stall holds the output register; reset clears the held surrogate, queue and valid.
module utf16_to_utf8_transcoder
  import u2u8_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic       push;
  logic       pop;
  job_t       new_job;
  job_t       head_job;
  fifo_stat_t stat;

  assign in_stall = stat.full;

  // front: surrogate tracking and encoding
  u2u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .job      (new_job)
  );

  // job queue
  u2u8_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (new_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (stat)
  );

  // back: byte serializer
  u2u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a queued job never overflows the queue and always has bytes
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full && new_job.cnt != '0 && new_job.cnt <= CNT_W'(MAX_BYTES))
    else $error("job pushed into full queue or with bad byte count");

  // string end only falls on the last byte of a word
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.string_done |-> out_data.last_of_run)
    else $error("string_done without last_of_run");

  // a four-byte lead is always followed by continuation bytes of the same word
  a_lead4_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_byte[7:3] == 5'b11110 |-> !out_data.last_of_run)
    else $error("four-byte lead marked as last byte");

endmodule

// ===== hw/rtl/u2u8_front.sv =====
module u2u8_front
  import u2u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_word_t   in_data,
  output logic       push,
  output job_t       job
);

  logic [9:0]       held_high_bits;
  logic             high_pending;

  logic [15:0]      c;
  logic             is_high;
  logic             is_low;
  logic             pair;
  logic             hold_new;
  logic             accept;
  logic [20:0]      cp;
  logic [15:0]      flush_unit;
  logic [2:0][7:0]  unit_bytes;
  logic [2:0][7:0]  flush_bytes;
  logic [CNT_W-1:0] unit_n;

  assign c        = in_data.code_unit;
  assign is_high  = c inside {[HIGH_FIRST:HIGH_LAST]};
  assign is_low   = c inside {[LOW_FIRST:LOW_LAST]};
  assign pair     = high_pending && is_low;
  assign hold_new = !pair && is_high && !in_data.end_of_string;
  assign accept   = in_valid && !in_stall;

  // supplementary code point of a surrogate pair
  assign cp = SUPP_BASE + {1'b0, held_high_bits, c[9:0]};

  // held high surrogate written alone as three bytes
  assign flush_unit  = HIGH_FIRST | {6'b0, held_high_bits};
  assign flush_bytes[0] = LEAD3 | {4'b0, flush_unit[15:12]};
  assign flush_bytes[1] = CONT  | {2'b0, flush_unit[11:6]};
  assign flush_bytes[2] = CONT  | {2'b0, flush_unit[5:0]};

  // single unit as one, two or three bytes
  always_comb begin
    unit_bytes = '0;
    if (c < ONE_BYTE_LIMIT) begin
      unit_bytes[0] = c[7:0];
      unit_n        = CNT_W'(1);
    end else if (c < TWO_BYTE_LIMIT) begin
      unit_bytes[0] = LEAD2 | {3'b0, c[10:6]};
      unit_bytes[1] = CONT  | {2'b0, c[5:0]};
      unit_n        = CNT_W'(2);
    end else begin
      unit_bytes[0] = LEAD3 | {4'b0, c[15:12]};
      unit_bytes[1] = CONT  | {2'b0, c[11:6]};
      unit_bytes[2] = CONT  | {2'b0, c[5:0]};
      unit_n        = CNT_W'(3);
    end
  end

  // build the job for this word
  always_comb begin
    job       = '0;
    job.eos   = in_data.end_of_string;
    if (pair) begin
      job.bytes[0] = LEAD4 | {5'b0, cp[20:18]};
      job.bytes[1] = CONT  | {2'b0, cp[17:12]};
      job.bytes[2] = CONT  | {2'b0, cp[11:6]};
      job.bytes[3] = CONT  | {2'b0, cp[5:0]};
      job.cnt      = CNT_W'(4);
    end else if (high_pending) begin
      job.bytes[0] = flush_bytes[0];
      job.bytes[1] = flush_bytes[1];
      job.bytes[2] = flush_bytes[2];
      job.bytes[3] = unit_bytes[0];
      job.bytes[4] = unit_bytes[1];
      job.bytes[5] = unit_bytes[2];
      job.cnt      = hold_new ? CNT_W'(3) : CNT_W'(3) + unit_n;
    end else begin
      job.bytes[0] = unit_bytes[0];
      job.bytes[1] = unit_bytes[1];
      job.bytes[2] = unit_bytes[2];
      job.cnt      = hold_new ? '0 : unit_n;
    end
  end

  // a held high surrogate alone queues nothing
  assign push = accept && (job.cnt != '0);

  // surrogate holding state
  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending   <= 1'b0;
      held_high_bits <= '0;
    end else if (accept) begin
      high_pending   <= hold_new;
      held_high_bits <= hold_new ? c[9:0] : '0;
    end
  end

endmodule

// ===== hw/rtl/u2u8_fifo.sv =====
module u2u8_fifo
  import u2u8_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  job_t       push_job,
  input  logic       pop,
  output job_t       head_job,
  output fifo_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign stat.full       = (fill == CW'(DEPTH));
  assign stat.head_valid = (fill != '0);
  assign head_job        = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/u2u8_back.sv =====
module u2u8_back
  import u2u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  fifo_stat_t stat,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data
);

  job_t             cur;
  logic             active;
  logic [CNT_W-1:0] idx;

  logic slot_free;
  logic emit;
  logic cur_last;

  assign slot_free = !out_valid || !out_stall;
  assign emit      = active && slot_free;
  assign cur_last  = (idx == cur.cnt - CNT_W'(1));
  assign pop       = stat.head_valid && (!active || (emit && cur_last));

  // job active flag, byte index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid <= emit;
      end
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (emit) begin
        if (cur_last) begin
          active <= 1'b0;
        end else begin
          idx <= idx + CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
    if (emit) begin
      out_data.out_byte    <= cur.bytes[idx];
      out_data.last_of_run <= cur_last;
      out_data.string_done <= cur_last && cur.eos;
    end
  end

endmodule
